[hw/rtl/bsc_pkg.sv]
// Shared types and constants for the bitmap set/clear/find-first block.
`default_nettype none

package bsc_pkg;

   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 9;
   localparam int SIZE_W   = 9;

   localparam logic [ACTION_W-1:0] ACT_SET   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

   typedef struct packed {
      logic start;  // word accepted: capture request, restart scan
      logic run;    // scan step
      logic load;   // move result into output register
   } bsc_cmd_type;

   typedef struct packed {
      logic scan_done;
   } bsc_sts_type;

endpackage

`default_nettype wire

[hw/rtl/bsc_if.sv]
// Valid/ready channel interfaces for request and response words.
`default_nettype none

interface bsc_req_if
   import bsc_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [INDEX_W-1:0]  flag_index;

   modport source (output valid, output action, output flag_index, input ready);
   modport sink   (input valid, input action, input flag_index, output ready);
endinterface

interface bsc_rsp_if
   import bsc_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic               status;
   logic [INDEX_W-1:0] first_set;
   logic [INDEX_W-1:0] first_clear;
   logic               full_res;
   logic [INDEX_W-1:0] set_count;

   modport source (output valid, output status, output first_set, output first_clear,
                   output full_res, output set_count, input ready);
   modport sink   (input valid, input status, input first_set, input first_clear,
                   input full_res, input set_count, output ready);
endinterface

`default_nettype wire

[hw/rtl/bsc_ctrl.sv]
// Controller: accept, scan sequencing and output register handshake.
`default_nettype none

module bsc_ctrl
   import bsc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   input  wire bsc_sts_type sts,
   output bsc_cmd_type      cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.run = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/bsc_datapath.sv]
// Datapath: flag memory, size register, word scan with update, result register.
`default_nettype none

module bsc_datapath
   import bsc_pkg::*;
#(
   parameter int MAX_BITS  = 256,
   parameter int WORD_BITS = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [SIZE_W-1:0]   csr_wr_data,
   input  wire logic [ACTION_W-1:0] req_action,
   input  wire logic [INDEX_W-1:0]  req_flag_index,
   input  wire bsc_cmd_type         cmd,
   output bsc_sts_type              sts,
   output logic                     rsp_status,
   output logic [INDEX_W-1:0]       rsp_first_set,
   output logic [INDEX_W-1:0]       rsp_first_clear,
   output logic                     rsp_full_res,
   output logic [INDEX_W-1:0]       rsp_set_count
);

   localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW_RAW    = $clog2(NUM_WORDS);
   localparam int AW        = (AW_RAW < 1) ? 1 : AW_RAW;
   localparam int CNT_W     = $clog2(NUM_WORDS + 1);
   localparam int BW_RAW    = $clog2(WORD_BITS);
   localparam int BW        = (BW_RAW < 1) ? 1 : BW_RAW;
   localparam int POP_W     = $clog2(WORD_BITS + 1);
   localparam int PW_RAW    = $clog2(MAX_BITS + WORD_BITS + 1);
   localparam int PW        = (PW_RAW < INDEX_W) ? INDEX_W : PW_RAW;

   // size register
   logic [SIZE_W-1:0] size_ff;
   logic [PW-1:0]     lim;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   assign lim = (PW'(size_ff) > PW'(MAX_BITS)) ? PW'(MAX_BITS) : PW'(size_ff);

   // captured request
   logic          is_set_ff;
   logic          do_mod_ff;
   logic          oob_ff;
   logic [PW-1:0] pos_ff;
   logic          is_write;
   logic          oob;

   assign is_write = (req_action == ACT_SET) || (req_action == ACT_CLEAR);
   assign oob      = is_write &&
                     ((req_flag_index == '0) || (PW'(req_flag_index) > lim));

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         is_set_ff <= (req_action == ACT_SET);
         do_mod_ff <= is_write && !oob;
         oob_ff    <= oob;
         pos_ff    <= PW'(req_flag_index) - PW'(1);
      end
   end

   // flag memory with per-word valid bits
   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [NUM_WORDS-1:0] valid_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_vld_ff;
   logic [AW-1:0]        rd_addr_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 rd_en;
   logic                 proc_en;
   logic                 wr_en;
   logic [WORD_BITS-1:0] mod_word;

   assign rd_en         = cmd.run && (cnt_ff < CNT_W'(NUM_WORDS));
   assign proc_en       = cmd.run && (cnt_ff != '0);
   assign sts.scan_done = (cnt_ff == CNT_W'(NUM_WORDS));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[rd_addr_ff] <= mod_word;
      end
      if (rd_en) begin
         rd_data_ff <= mem[cnt_ff[AW-1:0]];
         rd_vld_ff  <= valid_ff[cnt_ff[AW-1:0]];
         rd_addr_ff <= cnt_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[rd_addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.start) begin
         cnt_ff <= '0;
      end else if (cmd.run && !sts.scan_done) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   // per-word update and search
   logic [WORD_BITS-1:0] word;
   logic [PW-1:0]        diff;
   logic                 hit;
   logic [BW-1:0]        bit_sel;
   logic [WORD_BITS-1:0] in_range;
   logic [WORD_BITS-1:0] set_bits;
   logic [WORD_BITS-1:0] clr_bits;
   logic [POP_W-1:0]     ones;
   logic                 fs_found, fc_found;
   logic [BW-1:0]        fs_off, fc_off;

   logic [PW-1:0] base_ff, base_in;
   logic [PW-1:0] first_set_ff, first_set_in;
   logic [PW-1:0] first_clear_ff, first_clear_in;
   logic [PW-1:0] count_ff, count_in;

   always_comb begin
      word    = rd_vld_ff ? rd_data_ff : '0;
      diff    = pos_ff - base_ff;
      hit     = do_mod_ff && (pos_ff >= base_ff) && (diff < PW'(WORD_BITS));
      bit_sel = diff[BW-1:0];
      wr_en   = proc_en && hit;

      mod_word = word;
      if (hit) begin
         mod_word[bit_sel] = is_set_ff;
      end

      for (int b = 0; b < WORD_BITS; b++) begin
         in_range[b] = (base_ff + PW'(b)) < lim;
      end
      set_bits = mod_word & in_range;
      clr_bits = ~mod_word & in_range;

      ones = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         ones = ones + POP_W'(set_bits[b]);
      end

      fs_found = 1'b0;
      fs_off   = '0;
      fc_found = 1'b0;
      fc_off   = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (set_bits[b]) begin
            fs_found = 1'b1;
            fs_off   = BW'(b);
         end
         if (clr_bits[b]) begin
            fc_found = 1'b1;
            fc_off   = BW'(b);
         end
      end

      base_in        = base_ff;
      first_set_in   = first_set_ff;
      first_clear_in = first_clear_ff;
      count_in       = count_ff;
      if (cmd.start) begin
         base_in        = '0;
         first_set_in   = '0;
         first_clear_in = '0;
         count_in       = '0;
      end else if (proc_en) begin
         base_in  = base_ff + PW'(WORD_BITS);
         count_in = count_ff + PW'(ones);
         if ((first_set_ff == '0) && fs_found) begin
            first_set_in = base_ff + PW'(fs_off) + PW'(1);
         end
         if ((first_clear_ff == '0) && fc_found) begin
            first_clear_in = base_ff + PW'(fc_off) + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff        <= base_in;
      first_set_ff   <= first_set_in;
      first_clear_ff <= first_clear_in;
      count_ff       <= count_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_status      <= oob_ff;
         rsp_first_set   <= first_set_ff[INDEX_W-1:0];
         rsp_first_clear <= first_clear_ff[INDEX_W-1:0];
         rsp_full_res    <= (first_clear_ff == '0);
         rsp_set_count   <= count_ff[INDEX_W-1:0];
      end
   end

endmodule

`default_nettype wire

[hw/rtl/bitmap_set_clear_find_first.sv]
// Top level of the bitmap flag allocator: controller plus datapath.
//
//   channel  dir  handshake        payload
//   req_if   in   valid/ready      action, flag_index
//   rsp_if   out  valid/ready      status, first_set, first_clear, full_res, set_count
//   csr      in   csr_wr_en        csr_wr_data (size in use)
//
// Each word runs one scan: the single memory read port visits every stored word once,
// updating the target word on the way.
// The next word is taken the cycle after the result loads, while that result may wait.
// Synchronous reset clears the flags (per-word valid bits) and sets the size to 256.
// A stalled response holds the scan result until the output register frees.
`default_nettype none

module bitmap_set_clear_find_first
   import bsc_pkg::*;
#(
   parameter int MAX_BITS  = 256,
   parameter int WORD_BITS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [SIZE_W-1:0] csr_wr_data,
   bsc_req_if.sink                req_if,
   bsc_rsp_if.source              rsp_if
);

   bsc_cmd_type cmd;
   bsc_sts_type sts;

   bsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bsc_datapath #(
      .MAX_BITS  (MAX_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_action      (req_if.action),
      .req_flag_index  (req_if.flag_index),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_status      (rsp_if.status),
      .rsp_first_set   (rsp_if.first_set),
      .rsp_first_clear (rsp_if.first_clear),
      .rsp_full_res    (rsp_if.full_res),
      .rsp_set_count   (rsp_if.set_count)
   );

endmodule

`default_nettype wire

[hw/rtl/bsc_checker.sv]
// Port-level checks for the bitmap allocator, bound to the top level.
`default_nettype none

module bsc_checker
   import bsc_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [INDEX_W-1:0] rsp_first_set,
   input wire logic [INDEX_W-1:0] rsp_first_clear,
   input wire logic               rsp_full_res,
   input wire logic [INDEX_W-1:0] rsp_set_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken during a scan");

   a_full_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_full_res == (rsp_first_clear == '0)))
      else $error("full flag disagrees with first clear");

   a_empty_no_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_set_count == '0) |-> (rsp_first_set == '0))
      else $error("first set reported with zero count");

   a_set_clear_differ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_first_set != '0) |-> (rsp_first_set != rsp_first_clear))
      else $error("same index reported set and clear");

endmodule

bind bitmap_set_clear_find_first bsc_checker u_bsc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_first_set   (rsp_if.first_set),
   .rsp_first_clear (rsp_if.first_clear),
   .rsp_full_res    (rsp_if.full_res),
   .rsp_set_count   (rsp_if.set_count)
);

`default_nettype wire
